// ===== design/barycentric_weights_2d_macros.svh =====
// Assertion macros shared by the barycentric weight block.
`ifndef BARYCENTRIC_WEIGHTS_2D_MACROS_SVH
`define BARYCENTRIC_WEIGHTS_2D_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, masked while reset is high
`define BDW_CHECK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("barycentric weights check failed");
// clocked check that also holds through reset
`define BDW_CHECK_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("barycentric weights reset check failed");
`else
`define BDW_CHECK(lbl, prop)
`define BDW_CHECK_RST(lbl, prop)
`endif
`endif

// ===== design/bdw_pkg.sv =====
// Shared types and constants for the barycentric weight block.
package bdw_pkg;
   localparam int W_BITS = 32;
   localparam int FRONT_STAGES = 5;
   localparam int FIN_STAGES = 2;
   localparam logic [W_BITS-1:0] W_MAX = {1'b0, {(W_BITS-1){1'b1}}};
   localparam logic [W_BITS-1:0] W_MIN = {1'b1, {(W_BITS-1){1'b0}}};

   typedef struct packed {
      logic degen;
      logic ovf_a;
      logic ovf_b;
      logic neg_a;
      logic neg_b;
   } side_type;
endpackage

// ===== design/bdw_req_if.sv =====
// Request channel: triangle vertices and query point.
interface bdw_req_if #(parameter int COORD_BITS = 16);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] ax;
   logic signed [COORD_BITS-1:0] ay;
   logic signed [COORD_BITS-1:0] bx;
   logic signed [COORD_BITS-1:0] by_coord;
   logic signed [COORD_BITS-1:0] cx;
   logic signed [COORD_BITS-1:0] cy;
   logic signed [COORD_BITS-1:0] px;
   logic signed [COORD_BITS-1:0] py;
   modport source (output valid, ax, ay, bx, by_coord, cx, cy, px, py, input ready);
   modport sink (input valid, ax, ay, bx, by_coord, cx, cy, px, py, output ready);
endinterface

// ===== design/bdw_rsp_if.sv =====
// Response channel: three weights and status flags.
interface bdw_rsp_if;
   import bdw_pkg::*;
   logic valid;
   logic ready;
   logic signed [W_BITS-1:0] weight_a;
   logic signed [W_BITS-1:0] weight_b;
   logic signed [W_BITS-1:0] weight_c;
   logic degenerate;
   logic saturated;
   modport source (output valid, weight_a, weight_b, weight_c, degenerate, saturated,
                   input ready);
   modport sink (input valid, weight_a, weight_b, weight_c, degenerate, saturated,
                 output ready);
endinterface

// ===== design/bdw_front.sv =====
// Edge functions, area term, magnitudes and divider setup.
module bdw_front #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic [bdw_pkg::FRONT_STAGES-1:0] en,
   input  logic signed [COORD_BITS-1:0] ax,
   input  logic signed [COORD_BITS-1:0] ay,
   input  logic signed [COORD_BITS-1:0] bx,
   input  logic signed [COORD_BITS-1:0] by_coord,
   input  logic signed [COORD_BITS-1:0] cx,
   input  logic signed [COORD_BITS-1:0] cy,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   output logic [2*COORD_BITS+1:0] ud_out,
   output logic [2*COORD_BITS+1:0] ra_out,
   output logic [2*COORD_BITS+1:0] rb_out,
   output logic [bdw_pkg::W_BITS-1:0] loa_out,
   output logic [bdw_pkg::W_BITS-1:0] lob_out,
   output bdw_pkg::side_type side_out
);
   import bdw_pkg::*;

   localparam int DIF_W = COORD_BITS + 1;
   localparam int PRD_W = 2 * COORD_BITS + 2;
   localparam int SUM_W = 2 * COORD_BITS + 3;
   localparam int MAG_W = 2 * COORD_BITS + 2;
   localparam int HI_W = MAG_W + FRAC_BITS;
   localparam int DV_W = HI_W + W_BITS;

   logic signed [DIF_W-1:0] e1_ff, e2_ff, e3_ff, e4_ff, f1_ff, f2_ff, g_ff;
   logic signed [PRD_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [SUM_W-1:0] d_ff, n0_ff, n1_ff;
   logic [MAG_W-1:0] ud_ff, ua_ff, ub_ff;
   logic degen_ff, neg_a_ff, neg_b_ff;
   logic [MAG_W-1:0] ud2_ff, ra_ff, rb_ff;
   logic [W_BITS-1:0] loa_ff, lob_ff;
   side_type side_ff;

   logic [DV_W-1:0] dva_in, dvb_in;
   logic [HI_W-1:0] hia_in, hib_in;

   always_comb begin
      dva_in = DV_W'(ua_ff) << FRAC_BITS;
      dvb_in = DV_W'(ub_ff) << FRAC_BITS;
      hia_in = dva_in[DV_W-1:W_BITS];
      hib_in = dvb_in[DV_W-1:W_BITS];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         e1_ff <= DIF_W'(by_coord) - DIF_W'(cy);
         e2_ff <= DIF_W'(cx) - DIF_W'(bx);
         e3_ff <= DIF_W'(cy) - DIF_W'(ay);
         e4_ff <= DIF_W'(ax) - DIF_W'(cx);
         f1_ff <= DIF_W'(px) - DIF_W'(cx);
         f2_ff <= DIF_W'(py) - DIF_W'(cy);
         g_ff  <= DIF_W'(ay) - DIF_W'(cy);
      end
      if (en[1]) begin
         p0_ff <= PRD_W'(e1_ff) * PRD_W'(e4_ff);
         p1_ff <= PRD_W'(e2_ff) * PRD_W'(g_ff);
         p2_ff <= PRD_W'(e1_ff) * PRD_W'(f1_ff);
         p3_ff <= PRD_W'(e2_ff) * PRD_W'(f2_ff);
         p4_ff <= PRD_W'(e3_ff) * PRD_W'(f1_ff);
         p5_ff <= PRD_W'(e4_ff) * PRD_W'(f2_ff);
      end
      if (en[2]) begin
         d_ff  <= SUM_W'(p0_ff) + SUM_W'(p1_ff);
         n0_ff <= SUM_W'(p2_ff) + SUM_W'(p3_ff);
         n1_ff <= SUM_W'(p4_ff) + SUM_W'(p5_ff);
      end
      if (en[3]) begin
         ud_ff <= d_ff[SUM_W-1] ? MAG_W'(-d_ff) : MAG_W'(d_ff);
         ua_ff <= n0_ff[SUM_W-1] ? MAG_W'(-n0_ff) : MAG_W'(n0_ff);
         ub_ff <= n1_ff[SUM_W-1] ? MAG_W'(-n1_ff) : MAG_W'(n1_ff);
         degen_ff <= (d_ff == '0);
         neg_a_ff <= n0_ff[SUM_W-1] ^ d_ff[SUM_W-1];
         neg_b_ff <= n1_ff[SUM_W-1] ^ d_ff[SUM_W-1];
      end
      if (en[4]) begin
         // quotient at or above 2^W_BITS shows up as high dividend part >= divisor
         ud2_ff <= ud_ff;
         ra_ff  <= hia_in[MAG_W-1:0];
         rb_ff  <= hib_in[MAG_W-1:0];
         loa_ff <= dva_in[W_BITS-1:0];
         lob_ff <= dvb_in[W_BITS-1:0];
         side_ff.degen <= degen_ff;
         side_ff.ovf_a <= (hia_in >= HI_W'(ud_ff));
         side_ff.ovf_b <= (hib_in >= HI_W'(ud_ff));
         side_ff.neg_a <= neg_a_ff;
         side_ff.neg_b <= neg_b_ff;
      end
   end

   assign ud_out = ud2_ff;
   assign ra_out = ra_ff;
   assign rb_out = rb_ff;
   assign loa_out = loa_ff;
   assign lob_out = lob_ff;
   assign side_out = side_ff;
endmodule

// ===== design/bdw_cell.sv =====
// One restoring-division cell: one quotient bit for each of the two weights.
module bdw_cell #(
   parameter int MAG_W = 34
) (
   input  logic clock,
   input  logic en,
   input  logic [MAG_W-1:0] ud_in,
   input  logic [MAG_W-1:0] ra_in,
   input  logic [MAG_W-1:0] rb_in,
   input  logic [bdw_pkg::W_BITS-1:0] loa_in,
   input  logic [bdw_pkg::W_BITS-1:0] lob_in,
   input  logic [bdw_pkg::W_BITS-1:0] qa_in,
   input  logic [bdw_pkg::W_BITS-1:0] qb_in,
   input  bdw_pkg::side_type side_in,
   output logic [MAG_W-1:0] ud_out,
   output logic [MAG_W-1:0] ra_out,
   output logic [MAG_W-1:0] rb_out,
   output logic [bdw_pkg::W_BITS-1:0] loa_out,
   output logic [bdw_pkg::W_BITS-1:0] lob_out,
   output logic [bdw_pkg::W_BITS-1:0] qa_out,
   output logic [bdw_pkg::W_BITS-1:0] qb_out,
   output bdw_pkg::side_type side_out
);
   import bdw_pkg::*;

   logic [MAG_W:0] ta_in, tb_in, da_in, db_in;
   logic bit_a_in, bit_b_in;
   logic [MAG_W-1:0] ud_ff, ra_ff, rb_ff;
   logic [W_BITS-1:0] loa_ff, lob_ff, qa_ff, qb_ff;
   side_type side_ff;

   always_comb begin
      ta_in = {ra_in, loa_in[W_BITS-1]};
      tb_in = {rb_in, lob_in[W_BITS-1]};
      da_in = ta_in - {1'b0, ud_in};
      db_in = tb_in - {1'b0, ud_in};
      bit_a_in = (ta_in >= {1'b0, ud_in});
      bit_b_in = (tb_in >= {1'b0, ud_in});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ud_ff  <= ud_in;
         ra_ff  <= bit_a_in ? da_in[MAG_W-1:0] : ta_in[MAG_W-1:0];
         rb_ff  <= bit_b_in ? db_in[MAG_W-1:0] : tb_in[MAG_W-1:0];
         loa_ff <= {loa_in[W_BITS-2:0], 1'b0};
         lob_ff <= {lob_in[W_BITS-2:0], 1'b0};
         qa_ff  <= {qa_in[W_BITS-2:0], bit_a_in};
         qb_ff  <= {qb_in[W_BITS-2:0], bit_b_in};
         side_ff <= side_in;
      end
   end

   assign ud_out = ud_ff;
   assign ra_out = ra_ff;
   assign rb_out = rb_ff;
   assign loa_out = loa_ff;
   assign lob_out = lob_ff;
   assign qa_out = qa_ff;
   assign qb_out = qb_ff;
   assign side_out = side_ff;
endmodule

// ===== design/bdw_fin.sv =====
// Sign, clamp and third weight.
module bdw_fin #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic [bdw_pkg::FIN_STAGES-1:0] en,
   input  logic [bdw_pkg::W_BITS-1:0] qa_in,
   input  logic [bdw_pkg::W_BITS-1:0] qb_in,
   input  bdw_pkg::side_type side_in,
   output logic signed [bdw_pkg::W_BITS-1:0] weight_a,
   output logic signed [bdw_pkg::W_BITS-1:0] weight_b,
   output logic signed [bdw_pkg::W_BITS-1:0] weight_c,
   output logic degenerate,
   output logic saturated
);
   import bdw_pkg::*;

   localparam int CW = W_BITS + 2;
   localparam logic signed [CW-1:0] ONE = CW'(1) <<< FRAC_BITS;
   localparam logic signed [CW-1:0] C_MAX = $signed({2'b00, W_MAX});
   localparam logic signed [CW-1:0] C_MIN = $signed({2'b11, W_MIN});

   function automatic logic [W_BITS:0] sign_clamp(input logic [W_BITS-1:0] q,
                                                   input logic neg, input logic ovf);
      logic [W_BITS:0] r;
      if (ovf)
         r = {1'b1, neg ? W_MIN : W_MAX};
      else if (neg)
         r = (q > W_MIN) ? {1'b1, W_MIN} : {1'b0, W_BITS'(-q)};
      else
         r = q[W_BITS-1] ? {1'b1, W_MAX} : {1'b0, q};
      return r;
   endfunction

   logic [W_BITS:0] ca_in, cb_in;
   logic signed [W_BITS-1:0] wa_ff, wb_ff, wao_ff, wbo_ff, wc_ff;
   logic sat_ab_ff, degen_ff, degen_o_ff, sat_o_ff;
   logic signed [CW-1:0] wc_in;

   always_comb begin
      ca_in = sign_clamp(qa_in, side_in.neg_a, side_in.ovf_a);
      cb_in = sign_clamp(qb_in, side_in.neg_b, side_in.ovf_b);
      wc_in = ONE - CW'(wa_ff) - CW'(wb_ff);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         wa_ff <= side_in.degen ? '0 : $signed(ca_in[W_BITS-1:0]);
         wb_ff <= side_in.degen ? '0 : $signed(cb_in[W_BITS-1:0]);
         sat_ab_ff <= !side_in.degen && (ca_in[W_BITS] || cb_in[W_BITS]);
         degen_ff <= side_in.degen;
      end
      if (en[1]) begin
         wao_ff <= wa_ff;
         wbo_ff <= wb_ff;
         degen_o_ff <= degen_ff;
         if (degen_ff) begin
            wc_ff <= '0;
            sat_o_ff <= 1'b0;
         end else if (wc_in > C_MAX) begin
            wc_ff <= $signed(W_MAX);
            sat_o_ff <= 1'b1;
         end else if (wc_in < C_MIN) begin
            wc_ff <= $signed(W_MIN);
            sat_o_ff <= 1'b1;
         end else begin
            wc_ff <= wc_in[W_BITS-1:0];
            sat_o_ff <= sat_ab_ff;
         end
      end
   end

   assign weight_a = wao_ff;
   assign weight_b = wbo_ff;
   assign weight_c = wc_ff;
   assign degenerate = degen_o_ff;
   assign saturated = sat_o_ff;
endmodule

// ===== design/barycentric_weights_2d.sv =====
// Barycentric weights of a point against a 2-D triangle, Q(FRAC_BITS) fixed point.
// Pipeline: 5 setup stages, 32 divider cells and 2 finish stages from request to result.
// One request per cycle unless rsp_chan stalls; a stage holds only if the next is full.
// The 32-cell divider chain makes up most of the pipeline, one quotient bit per cell.
// Synchronous reset clears all stage valid bits; data registers are not reset.
`include "barycentric_weights_2d_macros.svh"
module barycentric_weights_2d #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   bdw_req_if.sink req_chan,
   bdw_rsp_if.source rsp_chan
);
   import bdw_pkg::*;

   localparam int MAG_W = 2 * COORD_BITS + 2;
   localparam int NS = FRONT_STAGES + W_BITS + FIN_STAGES;
   localparam int CW = W_BITS + 2;
   localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

   logic [NS-1:0] v_ff, en;

   logic [MAG_W-1:0] ud_c [0:W_BITS];
   logic [MAG_W-1:0] ra_c [0:W_BITS];
   logic [MAG_W-1:0] rb_c [0:W_BITS];
   logic [W_BITS-1:0] loa_c [0:W_BITS];
   logic [W_BITS-1:0] lob_c [0:W_BITS];
   logic [W_BITS-1:0] qa_c [0:W_BITS];
   logic [W_BITS-1:0] qb_c [0:W_BITS];
   side_type side_c [0:W_BITS];

   // a stage loads when it is empty or its contents move on
   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_chan.ready;
      for (int i = NS - 2; i >= 0; i--)
         en[i] = !v_ff[i] || en[i+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0])
            v_ff[0] <= req_chan.valid;
         for (int i = 1; i < NS; i++)
            if (en[i])
               v_ff[i] <= v_ff[i-1];
      end
   end

   assign req_chan.ready = en[0];
   assign rsp_chan.valid = v_ff[NS-1];

   bdw_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock),
      .en(en[FRONT_STAGES-1:0]),
      .ax(req_chan.ax), .ay(req_chan.ay),
      .bx(req_chan.bx), .by_coord(req_chan.by_coord),
      .cx(req_chan.cx), .cy(req_chan.cy),
      .px(req_chan.px), .py(req_chan.py),
      .ud_out(ud_c[0]), .ra_out(ra_c[0]), .rb_out(rb_c[0]),
      .loa_out(loa_c[0]), .lob_out(lob_c[0]),
      .side_out(side_c[0])
   );

   assign qa_c[0] = '0;
   assign qb_c[0] = '0;

   for (genvar k = 0; k < W_BITS; k++) begin : g_cell
      bdw_cell #(.MAG_W(MAG_W)) u_cell (
         .clock(clock),
         .en(en[FRONT_STAGES+k]),
         .ud_in(ud_c[k]), .ra_in(ra_c[k]), .rb_in(rb_c[k]),
         .loa_in(loa_c[k]), .lob_in(lob_c[k]),
         .qa_in(qa_c[k]), .qb_in(qb_c[k]),
         .side_in(side_c[k]),
         .ud_out(ud_c[k+1]), .ra_out(ra_c[k+1]), .rb_out(rb_c[k+1]),
         .loa_out(loa_c[k+1]), .lob_out(lob_c[k+1]),
         .qa_out(qa_c[k+1]), .qb_out(qb_c[k+1]),
         .side_out(side_c[k+1])
      );
   end

   bdw_fin #(.FRAC_BITS(FRAC_BITS)) u_fin (
      .clock(clock),
      .en(en[NS-1:NS-FIN_STAGES]),
      .qa_in(qa_c[W_BITS]),
      .qb_in(qb_c[W_BITS]),
      .side_in(side_c[W_BITS]),
      .weight_a(rsp_chan.weight_a),
      .weight_b(rsp_chan.weight_b),
      .weight_c(rsp_chan.weight_c),
      .degenerate(rsp_chan.degenerate),
      .saturated(rsp_chan.saturated)
   );

   `BDW_CHECK_RST(a_reset_empty, reset |=> (v_ff == '0))
   `BDW_CHECK(a_degen_zero, rsp_chan.valid && rsp_chan.degenerate |->
      (rsp_chan.weight_a == '0) && (rsp_chan.weight_b == '0) &&
      (rsp_chan.weight_c == '0) && !rsp_chan.saturated)
   `BDW_CHECK(a_sat_extreme, rsp_chan.valid && rsp_chan.saturated |->
      (rsp_chan.weight_a == W_MAX) || (rsp_chan.weight_a == W_MIN) ||
      (rsp_chan.weight_b == W_MAX) || (rsp_chan.weight_b == W_MIN) ||
      (rsp_chan.weight_c == W_MAX) || (rsp_chan.weight_c == W_MIN))
   `BDW_CHECK(a_sum_one, rsp_chan.valid && !rsp_chan.degenerate && !rsp_chan.saturated |->
      (CW'(rsp_chan.weight_a) + CW'(rsp_chan.weight_b) + CW'(rsp_chan.weight_c) == ONE))
endmodule
